/* rtl/core/aesbc_pkg.sv */
// Shared constants and helper functions for the AES block cipher core.
// Holds the S-box tables, GF(2^8) column mixing and row shifting.
// No dependencies; used by every module of the core.
package aesbc_pkg;

  localparam int unsigned KeyStoreDepth = 60;
  localparam int unsigned KeyAddrW      = 6;
  localparam int unsigned CfgIdxW       = 3;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegKeyWord0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyWord1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyWord2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyWord3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeyLen   = 3'd4;

  // Key length codes
  localparam logic [1:0] KeyLen128 = 2'd0;
  localparam logic [1:0] KeyLen192 = 2'd1;

  localparam logic [7:0] RconInit = 8'h01;

  localparam logic [7:0] FwdSbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Multiply by a matrix coefficient; idx picks {2,3,1,1} or {e,b,d,9}
  function automatic logic [7:0] coef_mul(input logic [7:0] a, input logic [1:0] idx,
                                          input logic inv);
    logic [7:0] x2, x4, x8, r;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    r  = a;
    if (!inv) begin
      case (idx)
        2'd0:    r = x2;
        2'd1:    r = x2 ^ a;
        default: r = a;
      endcase
    end else begin
      case (idx)
        2'd0:    r = x8 ^ x4 ^ x2;
        2'd1:    r = x8 ^ x2 ^ a;
        2'd2:    r = x8 ^ x4 ^ a;
        default: r = x8 ^ a;
      endcase
    end
    return r;
  endfunction

  // Mix one column, row 0 in the top byte
  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [31:0] res;
    logic [7:0]  acc;
    for (int r = 0; r < 4; r++) begin
      acc = 8'h00;
      for (int k = 0; k < 4; k++) begin
        acc ^= coef_mul(col[31-8*k -: 8], 2'((k + 4 - r) % 4), inv);
      end
      res[31-8*r -: 8] = acc;
    end
    return res;
  endfunction

  // Row shift of the whole state, byte 0 in the top bits
  function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? (((c + 4 - r) % 4) * 4 + r) : (((c + r) % 4) * 4 + r);
        t[127-8*(c*4+r) -: 8] = s[127-8*src -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FwdSbox[w[31:24]], FwdSbox[w[23:16]], FwdSbox[w[15:8]], FwdSbox[w[7:0]]};
  endfunction

  // Number of rounds for a key length code
  function automatic logic [3:0] rounds_of(input logic [1:0] code);
    logic [3:0] n;
    case (code)
      KeyLen128: n = 4'd10;
      KeyLen192: n = 4'd12;
      default:   n = 4'd14;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/aes_block_cipher_core.sv */
// AES-128/192/256 block cipher top level: key registers, output register.
// Depends on aesbc_pkg, aesbc_key_expand, aesbc_round_engine.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   input    | in_valid_i / in_stall_o| action_i, data_hi_i, data_lo_i
//   output   | out_valid_o/out_stall_i| data_out_hi_o, data_out_lo_o
//   config   | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// An item is processed round by round through the byte-serial S-box, the row shift and,
// per column, a key address and a key use step on the single key store read port.
// Its result is loaded into the output register once that register is free or being
// taken; the next item is taken only after the previous result has left the engine.
// Reset, and any key or length write, start a word-by-word key expansion once the
// engine is idle; the input stalls until it ends.
// While the output register is stalled, a finished result waits in the engine.
module aes_block_cipher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aesbc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [63:0]                   data_hi_i,
  input  logic [63:0]                   data_lo_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   data_out_hi_o,
  output logic [63:0]                   data_out_lo_o
);

  logic [3:0][63:0]               key_q;
  logic [1:0]                     key_len_q;
  logic                           stale_q;
  logic                           kx_start, kx_busy;
  logic [aesbc_pkg::KeyAddrW-1:0] key_addr;
  logic [31:0]                    key_word;
  logic                           eng_idle, eng_done, eng_take, in_accept;
  logic [127:0]                   eng_result;
  logic                           out_valid_q;
  logic [127:0]                   out_data_q;
  logic                           cfg_hit;

  assign cfg_hit   = cfg_we_i && (cfg_idx_i <= aesbc_pkg::RegKeyLen);
  assign kx_start  = stale_q && !kx_busy && eng_idle;
  assign in_stall_o = !(eng_idle && !stale_q && !kx_busy);
  assign in_accept = in_valid_i && !in_stall_o;
  assign eng_take  = eng_done && (!out_valid_q || !out_stall_i);

  // Key registers and re-expansion flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= aesbc_pkg::KeyLen128;
      stale_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          aesbc_pkg::RegKeyWord0: key_q[0] <= cfg_data_i;
          aesbc_pkg::RegKeyWord1: key_q[1] <= cfg_data_i;
          aesbc_pkg::RegKeyWord2: key_q[2] <= cfg_data_i;
          aesbc_pkg::RegKeyWord3: key_q[3] <= cfg_data_i;
          aesbc_pkg::RegKeyLen:   key_len_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        stale_q <= 1'b1;
      end else if (kx_start) begin
        stale_q <= 1'b0;
      end
    end
  end

  aesbc_key_expand u_key_expand (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (kx_start),
    .key_i     (key_q),
    .key_len_i (key_len_q),
    .rd_addr_i (key_addr),
    .rd_data_o (key_word),
    .busy_o    (kx_busy)
  );

  aesbc_round_engine u_round_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .decrypt_i  (action_i),
    .block_i    ({data_hi_i, data_lo_i}),
    .rounds_i   (aesbc_pkg::rounds_of(key_len_q)),
    .key_word_i (key_word),
    .key_addr_o (key_addr),
    .idle_o     (eng_idle),
    .done_o     (eng_done),
    .take_i     (eng_take),
    .result_o   (eng_result)
  );

  // Output register: load a finished item, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_take) begin
      out_data_q <= eng_result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_out_hi_o = out_data_q[127:64];
  assign data_out_lo_o = out_data_q[63:0];

endmodule

/* rtl/core/aesbc_key_expand.sv */
// Round-key store and word-serial key expansion sequencer.
// Depends on aesbc_pkg (S-box, key length codes).
// Each key word takes an issue step and a write step through one shared read port.
module aesbc_key_expand (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [3:0][63:0]                  key_i,
  input  logic [1:0]                        key_len_i,
  input  logic [aesbc_pkg::KeyAddrW-1:0]    rd_addr_i,
  output logic [31:0]                       rd_data_o,
  output logic                              busy_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StWrite = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [aesbc_pkg::KeyAddrW-1:0] idx_q, idx_d;
  logic [2:0]                     mod_q, mod_d;
  logic [3:0]                     nk_q, nk_d;
  logic [7:0]                     rcon_q, rcon_d;
  logic [31:0]                    prev_q, prev_d;
  logic [aesbc_pkg::KeyAddrW-1:0] last_idx;
  logic [aesbc_pkg::KeyAddrW-1:0] mem_addr;
  logic [31:0]                    word_new, tmp, key_w;
  logic                           we;
  logic [31:0]                    mem [aesbc_pkg::KeyStoreDepth];
  logic [31:0]                    rd_data_q;

  // Last word index follows the latched key length
  always_comb begin
    case (nk_q)
      4'd4:    last_idx = 6'd43;
      4'd6:    last_idx = 6'd51;
      default: last_idx = 6'd59;
    endcase
  end

  assign key_w = idx_q[0] ? key_i[idx_q[2:1]][31:0] : key_i[idx_q[2:1]][63:32];

  // Compute the next word from the previous one and the word nk back
  always_comb begin
    tmp    = prev_q;
    rcon_d = rcon_q;
    if (mod_q == 3'd0) begin
      tmp    = aesbc_pkg::sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon_q, 24'h0};
      rcon_d = aesbc_pkg::xtime(rcon_q);
    end else if (nk_q == 4'd8 && mod_q == 3'd4) begin
      tmp = aesbc_pkg::sub_word(prev_q);
    end
    word_new = (idx_q < {2'b00, nk_q}) ? key_w : (rd_data_q ^ tmp);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    mod_d   = mod_q;
    nk_d    = nk_q;
    prev_d  = prev_q;
    we      = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StIssue;
          idx_d   = '0;
          mod_d   = '0;
          nk_d    = (key_len_i == aesbc_pkg::KeyLen128) ? 4'd4 :
                    (key_len_i == aesbc_pkg::KeyLen192) ? 4'd6 : 4'd8;
        end
      end
      StIssue: state_d = StWrite;
      StWrite: begin
        we     = 1'b1;
        prev_d = word_new;
        if (idx_q == last_idx) begin
          state_d = StIdle;
        end else begin
          state_d = StIssue;
          idx_d   = idx_q + 6'd1;
          mod_d   = ({1'b0, mod_q} == nk_q - 4'd1) ? 3'd0 : mod_q + 3'd1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o   = (state_q != StIdle);
  assign mem_addr = busy_o ? (idx_q - {2'b00, nk_q}) : rd_addr_i;
  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      mod_q   <= '0;
      nk_q    <= 4'd4;
      rcon_q  <= aesbc_pkg::RconInit;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      mod_q   <= mod_d;
      nk_q    <= nk_d;
      if (state_q == StIdle) begin
        rcon_q <= aesbc_pkg::RconInit;
      end else if (we && idx_q >= {2'b00, nk_q}) begin
        rcon_q <= rcon_d;
      end
    end
  end

  // Round-key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    prev_q    <= prev_d;
    rd_data_q <= mem[mem_addr];
    if (we) begin
      mem[idx_q] <= word_new;
    end
  end

endmodule

/* rtl/core/aesbc_round_engine.sv */
// Byte-serial AES round engine: S-box one byte per cycle, column mix and
// round key one column per step. Depends on aesbc_pkg.
module aesbc_round_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           decrypt_i,
  input  logic [127:0]                   block_i,
  input  logic [3:0]                     rounds_i,
  input  logic [31:0]                    key_word_i,
  output logic [aesbc_pkg::KeyAddrW-1:0] key_addr_o,
  output logic                           idle_o,
  output logic                           done_o,
  input  logic                           take_i,
  output logic [127:0]                   result_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StKAddr = 3'd1;
  localparam logic [2:0] StKUse  = 3'd2;
  localparam logic [2:0] StSub   = 3'd3;
  localparam logic [2:0] StShift = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]   state_q, state_d;
  logic [127:0] st_q, st_d;
  logic [3:0]   rd_q, rd_d;
  logic [1:0]   col_q, col_d;
  logic [3:0]   cnt_q, cnt_d;
  logic         dec_q, dec_d;
  logic [3:0]   nr_q, nr_d;
  logic [31:0]  col_in, col_out, keyed;
  logic         do_mix, last_rd;
  logic [7:0]   sb_out;

  assign do_mix  = (rd_q != 4'd0) && (rd_q != nr_q);
  assign last_rd = dec_q ? (rd_q == 4'd0) : (rd_q == nr_q);
  assign col_in  = st_q[127:96];
  assign keyed   = col_in ^ key_word_i;
  assign sb_out  = dec_q ? aesbc_pkg::InvSbox[st_q[127:120]]
                         : aesbc_pkg::FwdSbox[st_q[127:120]];

  // Column step: encrypt mixes before the key, decrypt after it
  always_comb begin
    if (!do_mix) begin
      col_out = keyed;
    end else if (dec_q) begin
      col_out = aesbc_pkg::mix_col(keyed, 1'b1);
    end else begin
      col_out = aesbc_pkg::mix_col(col_in, 1'b0) ^ key_word_i;
    end
  end

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    rd_d    = rd_q;
    col_d   = col_q;
    cnt_d   = cnt_q;
    dec_d   = dec_q;
    nr_d    = nr_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          st_d    = block_i;
          dec_d   = decrypt_i;
          nr_d    = rounds_i;
          rd_d    = decrypt_i ? rounds_i : 4'd0;
          col_d   = 2'd0;
          state_d = StKAddr;
        end
      end
      StKAddr: state_d = StKUse;
      StKUse: begin
        st_d  = {st_q[95:0], col_out};
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) begin
          if (last_rd) begin
            state_d = StDone;
          end else begin
            rd_d    = dec_q ? rd_q - 4'd1 : rd_q + 4'd1;
            cnt_d   = 4'd0;
            state_d = StSub;
          end
        end else begin
          state_d = StKAddr;
        end
      end
      StSub: begin
        st_d  = {st_q[119:0], sb_out};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = StShift;
        end
      end
      StShift: begin
        st_d    = aesbc_pkg::rotate_rows(st_q, dec_q);
        col_d   = 2'd0;
        state_d = StKAddr;
      end
      StDone: begin
        if (take_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign key_addr_o = {rd_q, col_q};
  assign idle_o     = (state_q == StIdle);
  assign done_o     = (state_q == StDone);
  assign result_o   = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rd_q    <= '0;
      col_q   <= '0;
      cnt_q   <= '0;
      dec_q   <= 1'b0;
      nr_q    <= 4'd10;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      col_q   <= col_d;
      cnt_q   <= cnt_d;
      dec_q   <= dec_d;
      nr_q    <= nr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for aes_block_cipher_core: encrypt/decrypt items under all key lengths.
// Depends on aesbc_pkg for the register indexes and key length codes; the cipher predictor
// is built here from its own derived S-box tables.

// Expected-result store with its own AES predictor and copy of the key registers
class aes_scoreboard;
  logic [7:0]   fwd_sbox [256];
  logic [7:0]   inv_sbox [256];
  logic [63:0]  key_reg [4];
  logic [1:0]   len_code;
  logic [31:0]  round_keys [60];
  logic [127:0] expected_blocks [$];
  int           error_count;

  function new();
    logic [7:0] p, b;
    for (int a = 0; a < 256; a++) begin
      // multiplicative inverse as a^254, zero maps to zero
      p = 8'h01;
      for (int k = 0; k < 254; k++) p = gf_mul(p, 8'(a));
      if (a == 0) p = 8'h00;
      b = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]} ^ {p[3:0], p[7:4]} ^ 8'h63;
      fwd_sbox[a] = b;
      inv_sbox[b] = 8'(a);
    end
    foreach (key_reg[i]) key_reg[i] = '0;
    len_code = aesbc_pkg::KeyLen128;
    error_count = 0;
    expand();
  endfunction

  function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function logic [31:0] sub_bytes4(logic [31:0] w);
    return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
  endfunction

  function int key_words();
    return (len_code == aesbc_pkg::KeyLen128) ? 4 : (len_code == aesbc_pkg::KeyLen192) ? 6 : 8;
  endfunction

  // Rebuild the round-key schedule from the key registers
  function void expand();
    int nk, total;
    logic [31:0] t;
    logic [7:0]  rcon;
    nk = key_words();
    total = 4 * (nk + 7);
    rcon = 8'h01;
    for (int i = 0; i < total; i++) begin
      if (i < nk) begin
        round_keys[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
      end else begin
        t = round_keys[i - 1];
        if (i % nk == 0) begin
          t = sub_bytes4({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
          rcon = gf_mul(rcon, 8'h02);
        end else if (nk > 6 && i % nk == 4) begin
          t = sub_bytes4(t);
        end
        round_keys[i] = round_keys[i - nk] ^ t;
      end
    end
  endfunction

  // Mirror a register write; unknown indexes leave the key untouched
  function void configure(logic [aesbc_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
    case (idx)
      aesbc_pkg::RegKeyWord0, aesbc_pkg::RegKeyWord1,
      aesbc_pkg::RegKeyWord2, aesbc_pkg::RegKeyWord3: key_reg[idx] = value;
      aesbc_pkg::RegKeyLen: len_code = value[1:0];
      default: return;
    endcase
    expand();
  endfunction

  function void key_xor(ref logic [7:0] s [16], input int round);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = round_keys[round * 4 + c];
      for (int r = 0; r < 4; r++) s[c * 4 + r] ^= w[31 - 8 * r -: 8];
    end
  endfunction

  function void sub_and_shift(ref logic [7:0] s [16], input bit inv);
    logic [7:0] t [16];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[c * 4 + r] = inv ? inv_sbox[s[((c + 4 - r) % 4) * 4 + r]]
                           : fwd_sbox[s[((c + r) % 4) * 4 + r]];
    s = t;
  endfunction

  function void column_mix(ref logic [7:0] s [16], input bit inv);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[c * 4 + k];
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], coef[(k + 4 - r) % 4]);
        s[c * 4 + r] = acc;
      end
    end
  endfunction

  function logic [127:0] cipher_block(bit decrypt, logic [127:0] blk);
    logic [7:0] s [16];
    int nr;
    nr = key_words() + 6;
    for (int b = 0; b < 16; b++) s[b] = blk[127 - 8 * b -: 8];
    if (!decrypt) begin
      key_xor(s, 0);
      for (int rd = 1; rd < nr; rd++) begin
        sub_and_shift(s, 0);
        column_mix(s, 0);
        key_xor(s, rd);
      end
      sub_and_shift(s, 0);
      key_xor(s, nr);
    end else begin
      key_xor(s, nr);
      for (int rd = nr - 1; rd > 0; rd--) begin
        sub_and_shift(s, 1);
        key_xor(s, rd);
        column_mix(s, 1);
      end
      sub_and_shift(s, 1);
      key_xor(s, 0);
    end
    for (int b = 0; b < 16; b++) blk[127 - 8 * b -: 8] = s[b];
    return blk;
  endfunction

  function void note_input(bit decrypt, logic [63:0] hi, logic [63:0] lo);
    expected_blocks.push_back(cipher_block(decrypt, {hi, lo}));
  endfunction

  function void check_result(logic [63:0] hi, logic [63:0] lo);
    logic [127:0] exp_blk;
    if (expected_blocks.size() == 0) begin
      $error("unexpected item: data_out_hi %h data_out_lo %h", hi, lo);
      error_count++;
      return;
    end
    exp_blk = expected_blocks.pop_front();
    if (hi !== exp_blk[127:64]) begin
      $error("data_out_hi: expected %h, got %h", exp_blk[127:64], hi);
      error_count++;
    end
    if (lo !== exp_blk[63:0]) begin
      $error("data_out_lo: expected %h, got %h", exp_blk[63:0], lo);
      error_count++;
    end
  endfunction

  function int pending();
    return expected_blocks.size();
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KeyLen256 = 2'd2;
  localparam logic [1:0] KeyLenSat = 2'd3;
  localparam int         DrainCycles = 500;
  localparam int         WatchdogLimit = 20000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [aesbc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [63:0]                   cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          action_i;
  logic [63:0]                   data_hi_i;
  logic [63:0]                   data_lo_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [63:0]                   data_out_hi_o;
  logic [63:0]                   data_out_lo_o;

  aes_scoreboard sb = new();
  bit            valid_held;
  bit            calm;
  int            idle_cycles;

  aes_block_cipher_core uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long; none while calm
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 20);
    return $urandom_range(50, 250);
  endfunction

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Check every item leaving the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(data_out_hi_o, data_out_lo_o);
  end

  // Toggle output stall in random bursts
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      repeat (gap_len()) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
    end
  end

  // End the run when no item moves for too long
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_item(bit act, logic [63:0] hi, logic [63:0] lo);
    int gap;
    in_valid_i <= 1'b1;
    action_i   <= act;
    data_hi_i  <= hi;
    data_lo_i  <= lo;
    valid_held = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(act, hi, lo);
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected item is out
  task automatic drain(int extra);
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [aesbc_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.configure(idx, value);
  endtask

  task automatic load_key(logic [1:0] code, logic [63:0] w0, logic [63:0] w1,
                          logic [63:0] w2, logic [63:0] w3);
    int unsigned spare;
    drain(DrainCycles);
    write_reg(aesbc_pkg::RegKeyWord0, w0);
    write_reg(aesbc_pkg::RegKeyWord1, w1);
    write_reg(aesbc_pkg::RegKeyWord2, w2);
    write_reg(aesbc_pkg::RegKeyWord3, w3);
    write_reg(aesbc_pkg::RegKeyLen, {$urandom(), $urandom()} & ~64'h3 | 64'(code));
    // unused indexes must be ignored
    spare = $urandom_range(int'(aesbc_pkg::RegKeyLen) + 1, (1 << aesbc_pkg::CfgIdxW) - 1);
    write_reg(spare[aesbc_pkg::CfgIdxW-1:0], rand_word());
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) send_item(1'($urandom_range(0, 1)), rand_word(), rand_word());
  endtask

  initial begin
    logic [1:0] code;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= aesbc_pkg::RegKeyWord0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    action_i   <= 1'b0;
    data_hi_i  <= '0;
    data_lo_i  <= '0;
    valid_held = 1'b0;
    calm = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key, extremes of the block, both actions
    send_item(1'b0, '0, '0);
    send_item(1'b1, '0, '0);
    send_item(1'b0, '1, '1);
    send_item(1'b1, '1, '1);
    send_item(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);

    // Directed: standard-style keys for each length, the saturating code, then an all-zero key
    load_key(aesbc_pkg::KeyLen128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send_item(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_item(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    load_key(aesbc_pkg::KeyLen192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '1);
    send_item(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_item(1'b1, '1, '0);
    load_key(KeyLen256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_item(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_item(1'b1, '0, '1);
    load_key(KeyLenSat, '1, '1, '1, '1);
    send_item(1'b0, '0, '0);
    send_item(1'b1, '1, '1);
    load_key(aesbc_pkg::KeyLen128, '0, '0, '0, '0);
    send_item(1'b0, '1, '0);
    send_item(1'b1, '0, '0);

    // Random phases over all key lengths, one without idling
    for (int ph = 0; ph < 10; ph++) begin
      code = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
      load_key(code, rand_word(), rand_word(), rand_word(), rand_word());
      calm = (ph == 5);
      if (ph == 2) begin
        random_items(100);
        drain(0);
        random_items(100);
      end else begin
        random_items(200);
      end
      calm = 1'b0;
    end

    drain(DrainCycles);
    if (sb.error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
